FILE: src/vvp_pkg.sv
`timescale 1ns / 1ps

package vvp_pkg;

  typedef enum logic [2:0] {
    REG_CAM_POS_X    = 3'd0,
    REG_CAM_POS_Y    = 3'd1,
    REG_CAM_POS_Z    = 3'd2,
    REG_YAW_COSINE   = 3'd3,
    REG_YAW_SINE     = 3'd4,
    REG_PITCH_COSINE = 3'd5,
    REG_PITCH_SINE   = 3'd6,
    REG_VIEWPORT     = 3'd7
  } cfg_reg_t;

  localparam logic signed [31:0] CAM_X_RST  = 32'sd0;
  localparam logic signed [31:0] CAM_Y_RST  = -32'sd327680;
  localparam logic signed [31:0] CAM_Z_RST  = -32'sd163840;
  localparam logic signed [17:0] ONE_Q      = 18'sd65536;

  // near plane 0.1 in Q16.16 and half focal factor sqrt(3)/2 in Q0.16
  localparam logic [31:0] NEAR_Q       = 32'd6554;
  localparam logic [15:0] HALF_FOCAL_Q = 16'd56756;

  // quotient bits of the ratio; the dividend is 48 bits wide
  localparam int QUO_W  = 35;
  localparam int DIV_ST = QUO_W;
  localparam int NUM_W  = 48;

  function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7fffffff;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat39(input logic signed [38:0] v);
    logic signed [31:0] r;
    if (v > 39'sd2147483647) r = 32'sh7fffffff;
    else if (v < -39'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat54(input logic signed [53:0] v);
    logic signed [31:0] r;
    if (v > 54'sd2147483647) r = 32'sh7fffffff;
    else if (v < -54'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: src/vertex_view_projection_core.sv
`timescale 1ns / 1ps
// Pipeline: 6 transform and setup stages, 35 stages of the radix-2 ratio divider,
// 3 scale/offset/output stages.
// Throughput: one item per cycle; the whole pipeline holds while a result is stalled.
// Reset (rst_n, synchronous, active low) clears all stage valid bits and loads the
// camera registers with their defaults; data registers are not reset.

module vertex_view_projection_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_screen_x,
  output logic signed [31:0] out_screen_y,
  output logic               out_depth_clamped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import vvp_pkg::*;

  localparam int NST = 6 + DIV_ST + 3;

  // configuration
  logic signed [31:0] cam_x_r, cam_y_r, cam_z_r;
  logic signed [17:0] yc_r, ys_r, pc_r, ps_r;
  logic [31:0]        vp_r;
  logic [15:0]        w_eff, h_eff;
  logic [31:0]        s_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= CAM_X_RST;
      cam_y_r <= CAM_Y_RST;
      cam_z_r <= CAM_Z_RST;
      yc_r    <= ONE_Q;
      ys_r    <= 18'sd0;
      pc_r    <= ONE_Q;
      ps_r    <= 18'sd0;
      vp_r    <= 32'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CAM_POS_X:    cam_x_r <= cfg_data;
        REG_CAM_POS_Y:    cam_y_r <= cfg_data;
        REG_CAM_POS_Z:    cam_z_r <= cfg_data;
        REG_YAW_COSINE:   yc_r    <= cfg_data[17:0];
        REG_YAW_SINE:     ys_r    <= cfg_data[17:0];
        REG_PITCH_COSINE: pc_r    <= cfg_data[17:0];
        REG_PITCH_SINE:   ps_r    <= cfg_data[17:0];
        REG_VIEWPORT:     vp_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = (vp_r[31:16] == 16'd0) ? 16'd1 : vp_r[31:16];
  assign h_eff = (vp_r[15:0] == 16'd0) ? 16'd1 : vp_r[15:0];

  always_ff @(posedge clk) begin
    s_r <= HALF_FOCAL_Q * h_eff;
  end

  // pipeline control
  logic [NST-1:0] v_r;
  logic           adv;

  assign adv       = !v_r[NST-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  // stage 1: translate
  logic               op_r [0:3];
  logic signed [31:0] rx_r [0:3];
  logic signed [31:0] ry_r [0:3];
  logic signed [31:0] rz_r [0:3];
  logic signed [32:0] tx_r, ty_r, tz_r, tz2_r, tz3_r;
  // stage 2/3: yaw
  logic signed [50:0] mxa_r, mxb_r, mya_r, myb_r;
  logic signed [51:0] sx1, sy1;
  logic signed [35:0] x1_r, y1_r, x1_4_r;
  // stage 4/5: pitch
  logic signed [53:0] mza_r, mwb_r;
  logic signed [50:0] mzb_r, mwa_r;
  logic signed [54:0] sy2, sz2;
  logic signed [31:0] cx_r, cy_r, cz_r;
  // stage 6: divider setup
  logic signed [32:0] dn;
  logic               clamp;
  logic [31:0]        dd;
  logic [32:0]        nx, ny;
  logic [31:0]        magx, magy;
  logic [NUM_W-1:0]   numx, numy;

  // divider stages, index 0 is the setup stage
  logic [31:0]      dvx_rem_r [0:DIV_ST];
  logic [31:0]      dvy_rem_r [0:DIV_ST];
  logic [QUO_W-1:0] dvx_low_r [0:DIV_ST];
  logic [QUO_W-1:0] dvy_low_r [0:DIV_ST];
  logic [31:0]      dv_d_r    [0:DIV_ST];
  logic             dv_negx_r [0:DIV_ST];
  logic             dv_negy_r [0:DIV_ST];
  logic             dv_clamp_r[0:DIV_ST];
  logic [31:0]      remx_nxt  [1:DIV_ST];
  logic [31:0]      remy_nxt  [1:DIV_ST];
  logic [QUO_W-1:0] lowx_nxt  [1:DIV_ST];
  logic [QUO_W-1:0] lowy_nxt  [1:DIV_ST];

  // scale, offset, output
  logic [50:0] phx_r, plx_r, phy_r, ply_r;
  logic [51:0] offx_r, offy_r;
  logic        negx_m_r, negy_m_r, clamp_m_r, negx_o_r, negy_o_r, clamp_o_r;
  logic signed [53:0] cen_x, cen_y, sum_x, sum_y;

  assign sx1 = mxa_r - mxb_r + 52'sd32768;
  assign sy1 = mya_r + myb_r + 52'sd32768;
  assign sy2 = mza_r + mzb_r + 55'sd32768;
  assign sz2 = mwa_r - mwb_r + 55'sd32768;

  always_comb begin
    dn    = 33'sd0 - {cz_r[31], cz_r};
    clamp = dn < $signed({1'b0, NEAR_Q});
    dd    = clamp ? NEAR_Q : dn[31:0];
    nx    = 33'd0 - {cx_r[31], cx_r};
    ny    = 33'd0 - {cy_r[31], cy_r};
    magx  = cx_r[31] ? nx[31:0] : cx_r;
    magy  = cy_r[31] ? ny[31:0] : cy_r;
    // add d/2 so the quotient rounds halves up
    numx  = {magx, 16'd0} + {17'd0, dd[31:1]};
    numy  = {magy, 16'd0} + {17'd0, dd[31:1]};
  end

  always_comb begin
    logic [32:0] trx, try_;
    for (int k = 1; k <= DIV_ST; k++) begin
      trx  = {dvx_rem_r[k-1], dvx_low_r[k-1][QUO_W-1]};
      try_ = {dvy_rem_r[k-1], dvy_low_r[k-1][QUO_W-1]};
      if (trx >= {1'b0, dv_d_r[k-1]}) begin
        remx_nxt[k] = 32'(trx - {1'b0, dv_d_r[k-1]});
        lowx_nxt[k] = {dvx_low_r[k-1][QUO_W-2:0], 1'b1};
      end else begin
        remx_nxt[k] = trx[31:0];
        lowx_nxt[k] = {dvx_low_r[k-1][QUO_W-2:0], 1'b0};
      end
      if (try_ >= {1'b0, dv_d_r[k-1]}) begin
        remy_nxt[k] = 32'(try_ - {1'b0, dv_d_r[k-1]});
        lowy_nxt[k] = {dvy_low_r[k-1][QUO_W-2:0], 1'b1};
      end else begin
        remy_nxt[k] = try_[31:0];
        lowy_nxt[k] = {dvy_low_r[k-1][QUO_W-2:0], 1'b0};
      end
    end
  end

  assign cen_x = $signed({23'd0, w_eff, 15'd0});
  assign cen_y = $signed({23'd0, h_eff, 15'd0});
  assign sum_x = negx_o_r ? cen_x - $signed({2'b00, offx_r})
                          : cen_x + $signed({2'b00, offx_r});
  assign sum_y = negy_o_r ? cen_y + $signed({2'b00, offy_r})
                          : cen_y - $signed({2'b00, offy_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      op_r[0] <= in_op;
      rx_r[0] <= in_point_x;
      ry_r[0] <= in_point_y;
      rz_r[0] <= in_point_z;
      tx_r    <= {in_point_x[31], in_point_x} - {cam_x_r[31], cam_x_r};
      ty_r    <= {in_point_y[31], in_point_y} - {cam_y_r[31], cam_y_r};
      tz_r    <= {in_point_z[31], in_point_z} - {cam_z_r[31], cam_z_r};
      for (int i = 1; i < 4; i++) begin
        rx_r[i] <= rx_r[i-1];
        ry_r[i] <= ry_r[i-1];
        rz_r[i] <= rz_r[i-1];
      end
      for (int i = 1; i < 4; i++) op_r[i] <= op_r[i-1];
      // stage 2
      mxa_r <= yc_r * tx_r;
      mxb_r <= ys_r * ty_r;
      mya_r <= ys_r * tx_r;
      myb_r <= yc_r * ty_r;
      tz2_r <= tz_r;
      // stage 3
      x1_r  <= sx1[51:16];
      y1_r  <= sy1[51:16];
      tz3_r <= tz2_r;
      // stage 4
      mza_r  <= pc_r * y1_r;
      mzb_r  <= ps_r * tz3_r;
      mwa_r  <= pc_r * tz3_r;
      mwb_r  <= ps_r * y1_r;
      x1_4_r <= x1_r;
      // stage 5: camera-space point, raw for op 1
      cx_r <= op_r[3] ? rx_r[3] : sat36(x1_4_r);
      cy_r <= op_r[3] ? ry_r[3] : sat39(sy2[54:16]);
      cz_r <= op_r[3] ? rz_r[3] : sat39(sz2[54:16]);
      // stage 6: the quotient fits 35 bits, so the top dividend bits start the remainder
      dvx_rem_r[0]  <= {19'd0, numx[NUM_W-1:QUO_W]};
      dvy_rem_r[0]  <= {19'd0, numy[NUM_W-1:QUO_W]};
      dvx_low_r[0]  <= numx[QUO_W-1:0];
      dvy_low_r[0]  <= numy[QUO_W-1:0];
      dv_d_r[0]     <= dd;
      dv_negx_r[0]  <= cx_r[31];
      dv_negy_r[0]  <= cy_r[31];
      dv_clamp_r[0] <= clamp;
      for (int k = 1; k <= DIV_ST; k++) begin
        dvx_rem_r[k]  <= remx_nxt[k];
        dvy_rem_r[k]  <= remy_nxt[k];
        dvx_low_r[k]  <= lowx_nxt[k];
        dvy_low_r[k]  <= lowy_nxt[k];
        dv_d_r[k]     <= dv_d_r[k-1];
        dv_negx_r[k]  <= dv_negx_r[k-1];
        dv_negy_r[k]  <= dv_negy_r[k-1];
        dv_clamp_r[k] <= dv_clamp_r[k-1];
      end
      // scale by s in two 16-bit halves
      phx_r     <= dvx_low_r[DIV_ST] * s_r[31:16];
      plx_r     <= dvx_low_r[DIV_ST] * s_r[15:0];
      phy_r     <= dvy_low_r[DIV_ST] * s_r[31:16];
      ply_r     <= dvy_low_r[DIV_ST] * s_r[15:0];
      negx_m_r  <= dv_negx_r[DIV_ST];
      negy_m_r  <= dv_negy_r[DIV_ST];
      clamp_m_r <= dv_clamp_r[DIV_ST];
      offx_r    <= {1'b0, phx_r} + (({1'b0, plx_r} + 52'd32768) >> 16);
      offy_r    <= {1'b0, phy_r} + (({1'b0, ply_r} + 52'd32768) >> 16);
      negx_o_r  <= negx_m_r;
      negy_o_r  <= negy_m_r;
      clamp_o_r <= clamp_m_r;
      // output
      out_screen_x      <= sat54(sum_x);
      out_screen_y      <= sat54(sum_y);
      out_depth_clamped <= clamp_o_r;
    end
  end

`ifndef ASSERT_OFF
  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[5] |-> (dv_d_r[0] >= NEAR_Q) && (dv_d_r[0] <= 32'h8000_0000))
    else $error("divisor out of range");

  a_clamp_near: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[5] && dv_clamp_r[0]) |-> (dv_d_r[0] == NEAR_Q))
    else $error("clamped depth is not the near plane");

  a_rem_below_d: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[5 + DIV_ST] |-> (dvx_rem_r[DIV_ST] < dv_d_r[DIV_ST]) &&
                        (dvy_rem_r[DIV_ST] < dv_d_r[DIV_ST]))
    else $error("divider remainder not below divisor");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r))
    else $error("pipeline moved while held");
`endif

endmodule

FILE: sim/tb_vertex_view_projection_core.sv
`timescale 1ns / 1ps

module tb_vertex_view_projection_core;
  import vvp_pkg::*;

  localparam int LATENCY = 44;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic               clamped;
  } screen_pt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = 1'b0;
  logic signed [31:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_screen_x, out_screen_y;
  logic out_depth_clamped;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  vertex_view_projection_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the camera registers
  logic [31:0] cam_reg [0:7];
  screen_pt_t  pending_pts[$];
  int mismatches = 0;
  int idle_pct = 15;
  int idle_cycles = 0;
  bit timed_out = 1'b0;

  function automatic logic signed [63:0] round_q16(input logic signed [63:0] v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [63:0] sat_word(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] axis_offset(input logic signed [63:0] c,
      input logic [63:0] d, input logic [63:0] s, input bit negate);
    logic [63:0] mag, r, off;
    logic signed [63:0] so;
    mag = (c < 0) ? -c : c;
    r = ((mag << 16) + (d >> 1)) / d;
    off = r * (s >> 16) + ((r * (s & 64'hFFFF) + 64'd32768) >> 16);
    so = off;
    if ((c < 0) != negate) so = -so;
    return so;
  endfunction

  function automatic screen_pt_t predict_screen(input bit op,
      input logic signed [31:0] px, input logic signed [31:0] py,
      input logic signed [31:0] pz);
    screen_pt_t r;
    logic signed [63:0] yc, ys, pc, ps, x, y, z, x1, y1, y2, z2, cx, cy, cz, d;
    logic [63:0] w, h, s;
    yc = 64'($signed(cam_reg[REG_YAW_COSINE][17:0]));
    ys = 64'($signed(cam_reg[REG_YAW_SINE][17:0]));
    pc = 64'($signed(cam_reg[REG_PITCH_COSINE][17:0]));
    ps = 64'($signed(cam_reg[REG_PITCH_SINE][17:0]));
    if (!op) begin
      x = 64'(px) - 64'($signed(cam_reg[REG_CAM_POS_X]));
      y = 64'(py) - 64'($signed(cam_reg[REG_CAM_POS_Y]));
      z = 64'(pz) - 64'($signed(cam_reg[REG_CAM_POS_Z]));
      x1 = round_q16(yc * x - ys * y);
      y1 = round_q16(ys * x + yc * y);
      y2 = round_q16(pc * y1 + ps * z);
      z2 = round_q16(pc * z - ps * y1);
      cx = sat_word(x1);
      cy = sat_word(y2);
      cz = sat_word(z2);
    end else begin
      cx = 64'(px);
      cy = 64'(py);
      cz = 64'(pz);
    end
    d = -cz;
    r.clamped = 1'b0;
    if (d < 64'sd6554) begin
      d = 64'sd6554;
      r.clamped = 1'b1;
    end
    w = 64'(cam_reg[REG_VIEWPORT][31:16]);
    h = 64'(cam_reg[REG_VIEWPORT][15:0]);
    if (w == 64'd0) w = 64'd1;
    if (h == 64'd0) h = 64'd1;
    s = 64'd56756 * h;
    r.sx = 32'(sat_word($signed(w << 15) + axis_offset(cx, d, s, 1'b0)));
    r.sy = 32'(sat_word($signed(h << 15) + axis_offset(cy, d, s, 1'b1)));
    return r;
  endfunction

  // valid stays high after the accept; whoever stops sending drops it
  task automatic send_point(input bit op, input logic [31:0] px,
      input logic [31:0] py, input logic [31:0] pz);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    pending_pts.push_back(predict_screen(op, px, py, pz));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cam_reg[idx] = (idx >= REG_YAW_COSINE && idx <= REG_PITCH_SINE) ?
                   {14'd0, val[17:0]} : val;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return {{16{1'b0}}, 16'($urandom())} - 32'h8000;
      2: return 32'h80000000 | $urandom_range(3);
      3: return 32'h7fffffff - $urandom_range(3);
      default: return $signed($urandom_range(1310720)) - 32'sd655360;
    endcase
  endfunction

  function automatic logic [31:0] rand_trig();
    case ($urandom_range(3))
      0: return 32'h10000;
      1: return 32'hFFFF0000;
      2: return $urandom();
      default: return $signed($urandom_range(131072)) - 32'sd65536;
    endcase
  endfunction

  task automatic test_defaults_directed();
    send_point(1'b0, 32'h0, 32'h0, 32'h0);
    send_point(1'b1, 32'h0, 32'h0, 32'hFFFF0000);
    send_point(1'b1, 32'h7fffffff, 32'h80000000, 32'h0);
    send_point(1'b1, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send_point(1'b1, 32'h10000, 32'h10000, 32'h7fffffff);
    send_point(1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFE666);
    send_point(1'b1, 32'h1, 32'h1, 32'hFFFFE667);
    send_point(1'b0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_point(1'b0, 32'h80000000, 32'h80000000, 32'h80000000);
    drain_and_settle();
  endtask

  task automatic test_extreme_camera();
    write_reg(REG_CAM_POS_X, 32'h80000000);
    write_reg(REG_CAM_POS_Y, 32'h7fffffff);
    write_reg(REG_CAM_POS_Z, 32'h7fffffff);
    write_reg(REG_YAW_COSINE, 32'h0001FFFF);
    write_reg(REG_YAW_SINE, 32'h00020000);
    write_reg(REG_PITCH_COSINE, 32'hFFFF0000);
    write_reg(REG_PITCH_SINE, 32'h0001FFFF);
    write_reg(REG_VIEWPORT, 32'hFFFFFFFF);
    send_point(1'b0, 32'h7fffffff, 32'h80000000, 32'h80000000);
    send_point(1'b0, 32'h0, 32'h0, 32'h0);
    send_point(1'b1, 32'h7fffffff, 32'h7fffffff, 32'hFFFF0000);
    drain_and_settle();
    write_reg(REG_VIEWPORT, 32'h0);
    drain_and_settle();
    write_reg(REG_VIEWPORT, 32'h00000280);
    send_point(1'b1, 32'h12345, 32'hFFF00000, 32'hFFFE0000);
    drain_and_settle();
    write_reg(REG_VIEWPORT, 32'h01E00000);
    send_point(1'b1, 32'h12345, 32'hFFF00000, 32'hFFFE0000);
    drain_and_settle();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        write_reg(REG_CAM_POS_X, 32'h0);
        write_reg(REG_CAM_POS_Y, 32'hFFFB0000);
        write_reg(REG_CAM_POS_Z, 32'hFFFD8000);
        write_reg(REG_YAW_COSINE, 32'h10000);
        write_reg(REG_YAW_SINE, 32'h0);
        write_reg(REG_PITCH_COSINE, 32'h10000);
        write_reg(REG_PITCH_SINE, 32'h0);
        write_reg(REG_VIEWPORT, 32'h028001E0);
      end else begin
        write_reg(REG_CAM_POS_X, rand_coord());
        write_reg(REG_CAM_POS_Y, rand_coord());
        write_reg(REG_CAM_POS_Z, rand_coord());
        write_reg(REG_YAW_COSINE, rand_trig());
        write_reg(REG_YAW_SINE, rand_trig());
        write_reg(REG_PITCH_COSINE, rand_trig());
        write_reg(REG_PITCH_SINE, rand_trig());
        write_reg(REG_VIEWPORT, $urandom());
      end
      // no idling in one phase
      idle_pct = (ph == 3) ? 0 : 15;
      for (int i = 0; i < 180; i++) begin
        send_point(1'($urandom()), rand_coord(), rand_coord(), rand_coord());
        // hold off until the pipeline is empty
        if (ph == 5 && i == 90) begin
          in_valid <= 1'b0;
          while (pending_pts.size() != 0) @(posedge clk);
        end
      end
      drain_and_settle();
    end
    idle_pct = 15;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      out_stall <= (idle_pct != 0) && ($urandom_range(99) < 15);
      if (in_valid && !in_stall) idle_cycles <= 0;
      else if (out_valid && !out_stall) idle_cycles <= 0;
      else if (pending_pts.size() != 0) idle_cycles <= idle_cycles + 1;
      else idle_cycles <= 0;
      if (out_valid && !out_stall) begin
        if (pending_pts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: x=%h y=%h", out_screen_x,
                                         out_screen_y);
        end else begin
          screen_pt_t e;
          e = pending_pts.pop_front();
          if (e.sx !== out_screen_x || e.sy !== out_screen_y ||
              e.clamped !== out_depth_clamped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp x=%h y=%h c=%b got x=%h y=%h c=%b", e.sx, e.sy,
                       e.clamped, out_screen_x, out_screen_y, out_depth_clamped);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("tb_vertex_view_projection_core: done, errors");
      $finish;
    end
  end

  initial begin
    cam_reg[0] = 32'h0;
    cam_reg[1] = 32'hFFFB0000;
    cam_reg[2] = 32'hFFFD8000;
    cam_reg[3] = 32'h10000;
    cam_reg[4] = 32'h0;
    cam_reg[5] = 32'h10000;
    cam_reg[6] = 32'h0;
    cam_reg[7] = 32'h0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults_directed();
    test_extreme_camera();
    test_random_phases();
    drain_and_settle();
    if (mismatches == 0 && pending_pts.size() == 0)
      $display("tb_vertex_view_projection_core: done, clean");
    else
      $display("tb_vertex_view_projection_core: done, errors");
    $finish;
  end

endmodule
